[rtl/core/mafc_pkg.sv]
// Shared types, widths and lookup tables for the MPEG audio frame check.
// Used by every module under rtl/core; no dependencies.
package mafc_pkg;

  localparam int HDR_W  = 32;
  localparam int LEN_W  = 16;
  localparam int SIZE_W = 12;
  localparam int KB_W   = 9;
  localparam int SCL_W  = 18;
  localparam int NUM_W  = 26;
  localparam int RATE_W = 17;
  localparam int QUO_W  = SIZE_W;
  localparam int DSR_W  = RATE_W + QUO_W - 1;
  localparam int REM_W  = DSR_W + 1;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 16;

  localparam logic [HDR_W-1:0] SYNC_MASK = 32'hffe0_0000;
  localparam logic [SCL_W-1:0] SCALE_L1  = 18'd12000;
  localparam logic [SCL_W-1:0] SCALE_L23 = 18'd144000;
  localparam logic [LEN_W-1:0] MIN_LEN   = 16'd4;

  localparam logic [1:0] LAYER_RSVD = 2'b00;
  localparam logic [1:0] RIDX_RSVD  = 2'b11;

  localparam logic [1:0] VER_MPEG1  = 2'd0;
  localparam logic [1:0] VER_MPEG2  = 2'd1;
  localparam logic [1:0] VER_MPEG25 = 2'd2;

  localparam logic [KB_W-1:0] KBPS_TAB [2][3][16] = '{
    '{ '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
         9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
       '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
         9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
       '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
         9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0} },
    '{ '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
         9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
       '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
         9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
       '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
         9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0} }
  };

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DSR_W-1:0] dsr;
    logic [QUO_W-1:0] quo;
    logic             pad;
    logic             l1;
    logic             hv;
    logic [LEN_W-1:0] plen;
  } div_word_t;

  typedef struct packed {
    logic              ok;
    logic [SIZE_W-1:0] size;
    logic              hv;
  } res_word_t;

  function automatic logic [RATE_W-1:0] rate_hz(input logic [1:0] ver,
                                                input logic [1:0] ridx);
    logic [RATE_W-1:0] r;
    r = '0;
    unique case ({ver, ridx})
      {VER_MPEG1, 2'd0}:  r = 17'd44100;
      {VER_MPEG1, 2'd1}:  r = 17'd48000;
      {VER_MPEG1, 2'd2}:  r = 17'd32000;
      {VER_MPEG2, 2'd0}:  r = 17'd22050;
      {VER_MPEG2, 2'd1}:  r = 17'd24000;
      {VER_MPEG2, 2'd2}:  r = 17'd16000;
      {VER_MPEG25, 2'd0}: r = 17'd11025;
      {VER_MPEG25, 2'd1}: r = 17'd12000;
      {VER_MPEG25, 2'd2}: r = 17'd8000;
      default:            r = '0;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/mpeg_audio_frame_check.sv]
// MPEG audio frame header check: decode cell, divider cell chain, tail cell.
// Depends on mafc_pkg, mafc_decode, mafc_div_cell, mafc_finish.
//
// Channel | Dir | Word bits (low to high)
// in_*    | in  | header_word[31:0], packet_length[47:32]
// out_*   | out | header_valid[0], frame_size[12:1], packet_ok[13], zero[15:14]
//
// One word accepted per cycle while the output is not stalled; each word passes
// decode, 12 divider cells and tail, one quotient bit per divider cell.
// Every cell holds its own valid bit, so bubbles collapse and input keeps
// flowing while a result waits at the output, until every cell is full.
// Reset (rst_n low, synchronous) empties all cells.
module mpeg_audio_frame_check (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [mafc_pkg::IN_DATA_W-1:0]    in_tdata,   // header_word, packet_length
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mafc_pkg::OUT_DATA_W-1:0]   out_tdata   // header_valid, frame_size, packet_ok
);

  mafc_pkg::div_word_t  chain_w [mafc_pkg::QUO_W+1];
  logic                 chain_v [mafc_pkg::QUO_W+1];
  logic                 chain_rdy [mafc_pkg::QUO_W+1];
  mafc_pkg::res_word_t  res;

  mafc_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .hdr       (in_tdata[31:0]),
    .plen      (in_tdata[47:32]),
    .out_valid (chain_v[0]),
    .out_ready (chain_rdy[0]),
    .out_word  (chain_w[0])
  );

  for (genvar i = 0; i < mafc_pkg::QUO_W; i++) begin : g_div
    mafc_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (chain_v[i]),
      .in_ready  (chain_rdy[i]),
      .in_word   (chain_w[i]),
      .out_valid (chain_v[i+1]),
      .out_ready (chain_rdy[i+1]),
      .out_word  (chain_w[i+1])
    );
  end

  mafc_finish u_finish (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (chain_v[mafc_pkg::QUO_W]),
    .in_ready  (chain_rdy[mafc_pkg::QUO_W]),
    .in_word   (chain_w[mafc_pkg::QUO_W]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_word  (res)
  );

  assign out_tdata = {2'b00, res.ok, res.size, res.hv};

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[12:1] == '0 && !out_tdata[13])
    else $error("invalid header with nonzero size or ok");

  a_ok_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[13] |-> out_tdata[0])
    else $error("packet_ok without header_valid");

  a_valid_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[12:1] != '0)
    else $error("valid header with zero frame size");

  a_block_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input blocked while output side can move");

endmodule

[rtl/core/mafc_decode.sv]
// Front cell: header field decode, bitrate/rate lookup, numerator multiply.
// Depends on mafc_pkg.
module mafc_decode (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mafc_pkg::HDR_W-1:0]    hdr,
  input  logic [mafc_pkg::LEN_W-1:0]    plen,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mafc_pkg::div_word_t           out_word
);

  logic [1:0]                     lcode;
  logic [1:0]                     ridx;
  logic [3:0]                     bidx;
  logic [1:0]                     li;
  logic                           lsf;
  logic [1:0]                     ver;
  logic [mafc_pkg::KB_W-1:0]      kb;
  logic [mafc_pkg::SCL_W-1:0]     scale;
  logic [mafc_pkg::RATE_W-1:0]    rate;
  logic [mafc_pkg::RATE_W-1:0]    den;
  logic [mafc_pkg::KB_W+mafc_pkg::SCL_W-1:0] prod;
  logic                           hv;
  logic                           v_r;
  mafc_pkg::div_word_t            w_r;
  mafc_pkg::div_word_t            w_nxt;

  assign lcode = hdr[18:17];
  assign ridx  = hdr[11:10];
  assign bidx  = hdr[15:12];
  assign li    = (lcode == mafc_pkg::LAYER_RSVD) ? 2'd0 : 2'd3 - lcode;
  assign lsf   = hdr[20] ? ~hdr[19] : 1'b1;
  assign ver   = !hdr[20] ? mafc_pkg::VER_MPEG25 :
                 (hdr[19] ? mafc_pkg::VER_MPEG1 : mafc_pkg::VER_MPEG2);
  assign kb    = mafc_pkg::KBPS_TAB[lsf][li][bidx];
  assign scale = (li == 2'd0) ? mafc_pkg::SCALE_L1 : mafc_pkg::SCALE_L23;
  assign rate  = mafc_pkg::rate_hz(ver, ridx);
  assign den   = (li == 2'd2 && lsf) ? {rate[mafc_pkg::RATE_W-2:0], 1'b0} : rate;
  assign prod  = kb * scale;

  assign hv = (plen >= mafc_pkg::MIN_LEN)
           && ((hdr & mafc_pkg::SYNC_MASK) == mafc_pkg::SYNC_MASK)
           && (lcode != mafc_pkg::LAYER_RSVD)
           && (ridx != mafc_pkg::RIDX_RSVD)
           && (kb != '0);

  always_comb begin
    w_nxt      = w_r;
    w_nxt.rem  = mafc_pkg::REM_W'(prod[mafc_pkg::NUM_W-1:0]);
    w_nxt.dsr  = {den, {(mafc_pkg::QUO_W-1){1'b0}}};
    w_nxt.quo  = '0;
    w_nxt.pad  = hdr[9];
    w_nxt.l1   = (li == 2'd0);
    w_nxt.hv   = hv;
    w_nxt.plen = plen;
  end

  assign in_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      w_r <= w_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_word  = w_r;

endmodule

[rtl/core/mafc_div_cell.sv]
// Restoring divider cell: one quotient bit per cell, remainder shifted on.
// Depends on mafc_pkg.
module mafc_div_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mafc_pkg::div_word_t  in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mafc_pkg::div_word_t  out_word
);

  logic                         ge;
  logic [mafc_pkg::REM_W-1:0]   dsr_x;
  logic [mafc_pkg::REM_W-1:0]   part;
  logic                         v_r;
  mafc_pkg::div_word_t          w_r;
  mafc_pkg::div_word_t          w_nxt;

  assign dsr_x = {1'b0, in_word.dsr};
  assign ge    = (in_word.rem >= dsr_x);
  assign part  = ge ? (in_word.rem - dsr_x) : in_word.rem;

  always_comb begin
    w_nxt     = in_word;
    w_nxt.rem = {part[mafc_pkg::REM_W-2:0], 1'b0};
    w_nxt.quo = {in_word.quo[mafc_pkg::QUO_W-2:0], ge};
  end

  assign in_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      w_r <= w_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_word  = w_r;

endmodule

[rtl/core/mafc_finish.sv]
// Tail cell: adds padding, scales Layer I slots, compares packet length.
// Depends on mafc_pkg.
module mafc_finish (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mafc_pkg::div_word_t  in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mafc_pkg::res_word_t  out_word
);

  logic [mafc_pkg::SIZE_W-1:0]  slots;
  logic [mafc_pkg::SIZE_W-1:0]  size;
  logic                         v_r;
  mafc_pkg::res_word_t          w_r;
  mafc_pkg::res_word_t          w_nxt;

  assign slots = in_word.quo + mafc_pkg::SIZE_W'(in_word.pad);
  assign size  = in_word.l1 ? {slots[mafc_pkg::SIZE_W-3:0], 2'b00} : slots;

  always_comb begin
    w_nxt.hv   = in_word.hv;
    w_nxt.size = in_word.hv ? size : '0;
    w_nxt.ok   = in_word.hv && (in_word.plen == mafc_pkg::LEN_W'(size));
  end

  assign in_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      w_r <= w_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_word  = w_r;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for mpeg_audio_frame_check: directed header table, then random headers.
// Depends on mafc_pkg and RTL under rtl/core; checked against typed rows or a local predictor.
module tb_top;

  localparam int unsigned LATENCY    = 14;
  localparam int unsigned HOLD_CYCLS = 64;
  localparam int unsigned RAND_WORDS = 1800;
  localparam int unsigned N_PHASES   = 4;
  localparam int unsigned CYCLE_MAX  = 200000;
  localparam int unsigned N_DIR      = 21;

  typedef enum int unsigned {LYR_I = 0, LYR_II = 1, LYR_III = 2} layer_t;

  typedef struct packed {
    logic                        hv;
    logic [mafc_pkg::SIZE_W-1:0] size;
    logic                        ok;
  } frame_chk_t;

  typedef struct packed {
    logic [mafc_pkg::HDR_W-1:0]  hdr;
    logic [mafc_pkg::LEN_W-1:0]  len;
    logic                        typed;
    logic                        hv;
    logic [mafc_pkg::SIZE_W-1:0] size;
    logic                        ok;
  } dir_row_t;

  localparam int unsigned KBPS [2][3][16] = '{
    '{ '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0},
       '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
       '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0} },
    '{ '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0},
       '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0},
       '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0} }
  };
  localparam int unsigned RATE_HZ [9] = '{44100, 48000, 32000, 22050, 24000, 16000,
                                          11025, 12000, 8000};

  localparam int unsigned SEND_IDLE  [N_PHASES] = '{0, 59, 0, 8};
  localparam int unsigned RECV_STALL [N_PHASES] = '{0, 0, 59, 8};

  // hdr, len, typed, hv, size, ok
  localparam dir_row_t DIRECTED [N_DIR] = '{
    '{32'h0000_0000, 16'd0,     1'b1, 1'b0, 12'd0,    1'b0},
    '{32'hFFFF_FFFF, 16'd65535, 1'b1, 1'b0, 12'd0,    1'b0},
    '{32'hFFFB_9000, 16'd417,   1'b1, 1'b1, 12'd417,  1'b1},
    '{32'hFFFB_9000, 16'd418,   1'b1, 1'b1, 12'd417,  1'b0},
    '{32'hFFFB_9000, 16'd3,     1'b1, 1'b0, 12'd0,    1'b0},
    '{32'hFFFB_9000, 16'd4,     1'b1, 1'b1, 12'd417,  1'b0},
    '{32'hFFFB_9000, 16'd65535, 1'b1, 1'b1, 12'd417,  1'b0},
    '{32'hFFFE_EA00, 16'd676,   1'b1, 1'b1, 12'd676,  1'b1},
    '{32'hFFE4_EA00, 16'd2881,  1'b1, 1'b1, 12'd2881, 1'b1},
    '{32'hFFFB_0000, 16'd100,   1'b1, 1'b0, 12'd0,    1'b0},
    '{32'hFFFB_F000, 16'd100,   1'b1, 1'b0, 12'd0,    1'b0},
    '{32'hFFF9_9000, 16'd417,   1'b1, 1'b0, 12'd0,    1'b0},
    '{32'hFFDB_9000, 16'd417,   1'b1, 1'b0, 12'd0,    1'b0},
    '{32'h7FFB_9000, 16'd417,   1'b1, 1'b0, 12'd0,    1'b0},
    '{32'hFFFB_9C00, 16'd417,   1'b1, 1'b0, 12'd0,    1'b0},
    '{32'hFFEA_8400, 16'd384,   1'b0, 1'b0, 12'd0,    1'b0},
    '{32'hFFF4_1400, 16'd48,    1'b0, 1'b0, 12'd0,    1'b0},
    '{32'hFFE2_1800, 16'd72,    1'b0, 1'b0, 12'd0,    1'b0},
    '{32'hFFFD_E600, 16'd1153,  1'b0, 1'b0, 12'd0,    1'b0},
    '{32'hFFF7_A000, 16'd100,   1'b0, 1'b0, 12'd0,    1'b0},
    '{32'hFFFF_1000, 16'd32,    1'b0, 1'b0, 12'd0,    1'b0}
  };

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [mafc_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [mafc_pkg::OUT_DATA_W-1:0] out_tdata;

  frame_chk_t  pending_checks[$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  bit          hold_req = 1'b0;

  mpeg_audio_frame_check u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  function automatic frame_chk_t calc_frame_check(logic [mafc_pkg::HDR_W-1:0] hdr,
                                                  logic [mafc_pkg::LEN_W-1:0] len);
    frame_chk_t  r;
    layer_t      lyr;
    int unsigned lsf, ver_row, kb, num, den, fsize;
    r = '0;
    if (len >= mafc_pkg::MIN_LEN && hdr[31:21] == '1 &&
        hdr[18:17] != mafc_pkg::LAYER_RSVD && hdr[11:10] != mafc_pkg::RIDX_RSVD) begin
      lyr = layer_t'(3 - hdr[18:17]);
      lsf = (hdr[20] && hdr[19]) ? 0 : 1;
      ver_row = !hdr[20] ? 2 : (hdr[19] ? 0 : 1);
      kb = KBPS[lsf][lyr][hdr[15:12]];
      if (kb != 0) begin
        num = kb * ((lyr == LYR_I) ? 12000 : 144000);
        den = RATE_HZ[ver_row * 3 + hdr[11:10]];
        if (lyr == LYR_III) den = den << lsf;
        fsize = num / den + hdr[9];
        if (lyr == LYR_I) fsize = fsize * 4;
        r.hv = 1'b1;
        r.size = fsize[mafc_pkg::SIZE_W-1:0];
        r.ok = (len == fsize[mafc_pkg::SIZE_W-1:0]);
      end
    end
    return r;
  endfunction

  // mostly well-formed headers with random content, the rest raw noise
  function automatic logic [mafc_pkg::HDR_W-1:0] rand_header();
    logic [mafc_pkg::HDR_W-1:0] h;
    h = $urandom();
    if ($urandom_range(99) < 85) begin
      h[31:21] = '1;
      if ($urandom_range(99) < 90)
        while (h[18:17] == mafc_pkg::LAYER_RSVD) h[18:17] = 2'($urandom_range(3));
      if ($urandom_range(99) < 90)
        while (h[11:10] == mafc_pkg::RIDX_RSVD) h[11:10] = 2'($urandom_range(3));
    end
    return h;
  endfunction

  function automatic logic [mafc_pkg::LEN_W-1:0] rand_length(
    logic [mafc_pkg::HDR_W-1:0] hdr);
    frame_chk_t  r;
    int unsigned pick;
    r = calc_frame_check(hdr, mafc_pkg::MIN_LEN);
    pick = $urandom_range(99);
    if (pick < 55) return mafc_pkg::LEN_W'(r.size);
    if (pick < 65)
      return mafc_pkg::LEN_W'(r.size) + ($urandom_range(1) ? 16'd1 : 16'hFFFF);
    if (pick < 75) return mafc_pkg::LEN_W'($urandom_range(5));
    return mafc_pkg::LEN_W'($urandom());
  endfunction

  task automatic send_word(input logic [mafc_pkg::HDR_W-1:0] hdr,
                           input logic [mafc_pkg::LEN_W-1:0] len,
                           input frame_chk_t expd);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {len, hdr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_checks.push_back(expd);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_checks.size() != 0) @(posedge clk);
  endtask

  // receiver: random stall, plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLS) @(negedge clk);
        hold_req = 1'b0;
      end
      out_tready <= rst_n && ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    frame_chk_t got, expd;
    if (rst_n && out_tvalid && out_tready) begin
      got.hv   = out_tdata[0];
      got.size = out_tdata[12:1];
      got.ok   = out_tdata[13];
      if (pending_checks.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected word: hv=%0b size=%0d ok=%0b", got.hv, got.size, got.ok);
      end else begin
        expd = pending_checks.pop_front();
        if (got.hv !== expd.hv || got.size !== expd.size || got.ok !== expd.ok) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: exp hv=%0b size=%0d ok=%0b, got hv=%0b size=%0d ok=%0b",
                     expd.hv, expd.size, expd.ok, got.hv, got.size, got.ok);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_MAX) begin
      $display("FAIL mpeg_audio_frame_check");
      $finish;
    end
  end

  initial begin
    logic [mafc_pkg::HDR_W-1:0] hdr;
    logic [mafc_pkg::LEN_W-1:0] len;
    frame_chk_t                 expd;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].typed)
        expd = '{hv: DIRECTED[i].hv, size: DIRECTED[i].size, ok: DIRECTED[i].ok};
      else
        expd = calc_frame_check(DIRECTED[i].hdr, DIRECTED[i].len);
      send_word(DIRECTED[i].hdr, DIRECTED[i].len, expd);
    end
    drain_results();

    for (int p = 0; p < N_PHASES; p++) begin
      idle_pct  = SEND_IDLE[p];
      stall_pct = RECV_STALL[p];
      for (int n = 0; n < RAND_WORDS / N_PHASES; n++) begin
        if (p == 0 && n == 100) hold_req = 1'b1;
        hdr = rand_header();
        len = rand_length(hdr);
        send_word(hdr, len, calc_frame_check(hdr, len));
      end
      drain_results();
    end

    repeat (2 * LATENCY) @(posedge clk);
    if (mismatch_cnt == 0 && pending_checks.size() == 0) begin
      $display("PASS mpeg_audio_frame_check");
    end else begin
      $display("FAIL mpeg_audio_frame_check");
    end
    $finish;
  end

endmodule
